// ----- sv/assert_macros.svh -----
// Assertion macros shared by the percent decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define PCTD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion checked also during reset
`define PCTD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/pctd_pkg.sv -----
// Package with types, constants and hex helpers for the percent decoder
`default_nettype none

package pctd_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam int unsigned MAX_OUT = 3;
	localparam int unsigned Q_DEPTH = 8;
	localparam int unsigned Q_AW = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		HELD_NONE = 2'd0,
		HELD_PCT  = 2'd1,
		HELD_HEX  = 2'd2
	} held_t;

	typedef struct packed {
		logic [1:0]                cnt;
		logic [MAX_OUT-1:0][7:0]   data;
		logic [MAX_OUT-1:0]        last;
	} push_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- sv/pctd_core.sv -----
// Input register, pending-escape state and decode of one byte into up to three bytes
`default_nettype none
`include "assert_macros.svh"

module pctd_core import pctd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_message,
	input  wire logic       room,
	output push_t           push
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eom_s1;
	held_t      held_q;
	logic [7:0] hex_q;

	held_t      held_d;
	logic [7:0] hex_d;
	logic       go;
	logic       load;
	logic       hex_b;
	logic       fresh_en;
	logic [1:0] pre_n;
	push_t      dec;

	assign go       = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
			eom_s1  <= end_of_message;
		end
	end

	always_comb begin
		dec      = '0;
		held_d   = held_q;
		hex_d    = hex_q;
		fresh_en = 1'b1;
		pre_n    = 2'd0;
		hex_b    = is_hex(byte_s1);
		unique case (held_q)
			HELD_PCT: begin
				if (hex_b) begin
					fresh_en = 1'b0;
					if (eom_s1) begin
						dec.data[0] = PCT_CHAR;
						dec.data[1] = byte_s1;
						dec.last[1] = 1'b1;
						dec.cnt     = 2'd2;
						held_d      = HELD_NONE;
						hex_d       = 8'h00;
					end else begin
						hex_d  = byte_s1;
						held_d = HELD_HEX;
					end
				end else begin
					dec.data[0] = PCT_CHAR;
					pre_n       = 2'd1;
				end
			end
			HELD_HEX: begin
				if (hex_b) begin
					fresh_en    = 1'b0;
					dec.data[0] = {hex_value(hex_q), hex_value(byte_s1)};
					dec.last[0] = eom_s1;
					dec.cnt     = 2'd1;
					held_d      = HELD_NONE;
					hex_d       = 8'h00;
				end else begin
					dec.data[0] = PCT_CHAR;
					dec.data[1] = hex_q;
					hex_d       = 8'h00;
					pre_n       = 2'd2;
				end
			end
			default: ;
		endcase
		if (fresh_en) begin
			dec.cnt = pre_n;
			if (byte_s1 == PCT_CHAR && !eom_s1) begin
				held_d = HELD_PCT;
			end else begin
				held_d           = HELD_NONE;
				dec.data[pre_n]  = byte_s1;
				dec.last[pre_n]  = eom_s1;
				dec.cnt          = pre_n + 2'd1;
			end
		end
	end

	always_comb begin
		push = dec;
		if (!go) begin
			push.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
			hex_q  <= 8'h00;
		end else if (go) begin
			held_q <= held_d;
			hex_q  <= hex_d;
		end
	end

	`PCTD_ASSERT(a_eom_clears, go && eom_s1 |=> held_q == HELD_NONE, "pending state survived message end")
	`PCTD_ASSERT(a_eom_emits, go && eom_s1 |-> push.cnt != 2'd0, "message end produced no byte")

endmodule

`default_nettype wire

// ----- sv/pctd_fifo.sv -----
// Output queue taking up to three decoded bytes per cycle and returning one per transaction
`default_nettype none
`include "assert_macros.svh"

module pctd_fifo import pctd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  push_t           push,
	output logic            room,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            last_of_message
);

	logic [7:0]     data_q [Q_DEPTH];
	logic           last_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            pop;

	assign room            = count_q <= (Q_AW+1)'(Q_DEPTH - MAX_OUT);
	assign out_valid       = count_q != '0;
	assign pop             = out_valid & ~out_stall;
	assign out_byte        = data_q[rd_ptr_q];
	assign last_of_message = last_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_OUT; i++) begin
			if (2'(i) < push.cnt) begin
				data_q[wr_ptr_q + Q_AW'(i)] <= push.data[i];
				last_q[wr_ptr_q + Q_AW'(i)] <= push.last[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + Q_AW'(pop);
			count_q  <= count_q + (Q_AW+1)'(push.cnt) - (Q_AW+1)'(pop);
		end
	end

	`PCTD_ASSERT(a_count_bound, count_q <= (Q_AW+1)'(Q_DEPTH), "queue count out of range")
	`PCTD_ASSERT(a_no_overflow, push.cnt != 2'd0 |-> room, "write into queue without space")

endmodule

`default_nettype wire

// ----- sv/permissive_percent_decoder.sv -----
// Permissive percent decoder: input register, decode logic and output queue
// Input channel: in_valid/in_stall with in_byte and end_of_message; a
// transaction moves one encoded byte, end_of_message on the last of a message.
// Output channel: out_valid/out_stall with out_byte and last_of_message.
// "%hh" (either case) becomes one byte; any broken escape is passed on
// literally and the following bytes are examined afresh. A pending escape is
// flushed at message end, and last_of_message marks the final decoded byte.
// Data path: a byte is registered, decoded into up to three bytes and written to
// an eight-entry output queue, whose head is presented on out_byte and is taken
// while out_valid is high and out_stall is low.
// Throughput: one input byte per cycle, one output byte per cycle. Input is
// stalled only while the queue holds more than five bytes, which the decode
// cannot reach while the output is drained every cycle.
// Reset clears the input register's valid flag, the pending escape and the queue.
// When the receiver stalls the queue fills and then the input is stalled.
`default_nettype none

module permissive_percent_decoder import pctd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_message,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            last_of_message
);

	push_t push;
	logic  room;

	pctd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_message (end_of_message),
		.room           (room),
		.push           (push)
	);

	pctd_fifo u_fifo (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.room            (room),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.last_of_message (last_of_message)
	);

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for permissive_percent_decoder: directed and random messages checked by a decode predictor
`timescale 1ns / 100ps

module tb_top;
	import pctd_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} dec_byte_t;

	localparam int IDLE_LIMIT = 1000;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [7:0] BORDER_CHARS [12] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67,
		8'h30, 8'h39, 8'h41, 8'h46, 8'h61, 8'h66};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_message;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_message;

	dec_byte_t  decoded_q[$];
	held_t      pend_state;
	logic [7:0] pend_hex;
	int         err_count = 0;
	int         idle_cnt = 0;
	bit         send_gaps = 1'b1;
	bit         stall_gaps = 1'b1;
	bit         hold_req = 1'b0;
	int         hold_left = 0;

	permissive_percent_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_message(last_of_message)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit hex_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c <= 8'h39) begin
			return 4'(c - 8'h30);
		end else if (c <= 8'h46) begin
			return 4'(c - 8'h37);
		end
		return 4'(c - 8'h57);
	endfunction

	function automatic logic [7:0] rand_hex();
		int r;
		r = $urandom_range(21);
		if (r < 10) begin
			return 8'(8'h30 + r);
		end else if (r < 16) begin
			return 8'(8'h41 + r - 10);
		end
		return 8'(8'h61 + r - 16);
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("%0t tb_top: %s: expected %02h, got %02h", $time, what, want, got);
		err_count++;
	endtask

	task automatic push_decoded(input logic [7:0] data, input logic last);
		dec_byte_t d;
		d.data = data;
		d.last = last;
		decoded_q.push_back(d);
	endtask

	task automatic decode_fresh(input logic [7:0] b, input logic eom);
		if (b == PCT_CHAR && !eom) begin
			pend_state = HELD_PCT;
		end else begin
			pend_state = HELD_NONE;
			push_decoded(b, eom);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eom);
		case (pend_state)
			HELD_PCT: begin
				if (hex_digit(b) && eom) begin
					push_decoded(PCT_CHAR, 1'b0);
					push_decoded(b, 1'b1);
					pend_state = HELD_NONE;
					pend_hex = 8'h00;
				end else if (hex_digit(b)) begin
					pend_hex = b;
					pend_state = HELD_HEX;
				end else begin
					push_decoded(PCT_CHAR, 1'b0);
					decode_fresh(b, eom);
				end
			end
			HELD_HEX: begin
				if (hex_digit(b)) begin
					push_decoded({nibble_of(pend_hex), nibble_of(b)}, eom);
					pend_state = HELD_NONE;
				end else begin
					push_decoded(PCT_CHAR, 1'b0);
					push_decoded(pend_hex, 1'b0);
					decode_fresh(b, eom);
				end
				pend_hex = 8'h00;
			end
			default: begin
				decode_fresh(b, eom);
			end
		endcase
	endtask

	// output check first, then prediction of the input transaction, then watchdog
	always @(posedge clk) begin
		dec_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("unexpected out_byte", 0, int'(out_byte));
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data) begin
					report_mismatch("out_byte", int'(want.data), int'(out_byte));
				end
				if (last_of_message !== want.last) begin
					report_mismatch("last_of_message", int'(want.last),
						int'(last_of_message));
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			decode_byte(in_byte, end_of_message);
		end
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
			idle_cnt = 0;
		end else if (in_valid || decoded_q.size() != 0) begin
			idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= stall_gaps && ($urandom_range(99) < 35);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eom);
		if (send_gaps) begin
			while ($urandom_range(99) < 35) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_message <= eom;
		do @(posedge clk); while (in_stall);
	endtask

	// mostly well-formed escapes with random digits, plus broken escapes and noise
	task automatic send_message(input int max_len, inout int sent);
		logic [7:0] msg[$];
		int n;
		int r;
		n = $urandom_range(max_len, 1);
		while (msg.size() < n) begin
			r = $urandom_range(99);
			if (r < 40) begin
				msg.push_back(PCT_CHAR);
				msg.push_back(rand_hex());
				msg.push_back(rand_hex());
			end else if (r < 55) begin
				msg.push_back(8'($urandom_range(255)));
			end else if (r < 65) begin
				msg.push_back(PCT_CHAR);
			end else if (r < 75) begin
				msg.push_back(PCT_CHAR);
				msg.push_back(BORDER_CHARS[4'($urandom_range(11))]);
				if ($urandom_range(1)) begin
					msg.push_back(BORDER_CHARS[4'($urandom_range(11))]);
				end
			end else if (r < 85) begin
				msg.push_back(BORDER_CHARS[4'($urandom_range(11))]);
			end else begin
				msg.push_back(8'($urandom_range(8'h7E, 8'h20)));
			end
		end
		foreach (msg[i]) begin
			send_byte(msg[i], i == msg.size() - 1);
		end
		sent += msg.size();
	endtask

	task automatic test_directed();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// plain escape ending the message
		send_byte(PCT_CHAR, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h31, 1'b1);
		// mixed case escape, then a lone percent at message end
		send_byte(PCT_CHAR, 1'b0);
		send_byte(8'h66, 1'b0);
		send_byte(8'h46, 1'b0);
		send_byte(PCT_CHAR, 1'b1);
		// double percent: first one literal, rest decoded
		send_byte(PCT_CHAR, 1'b0);
		send_byte(PCT_CHAR, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h31, 1'b1);
		// broken first digit at message end
		send_byte(PCT_CHAR, 1'b0);
		send_byte(8'h67, 1'b1);
		// hex digit arriving with message end after a percent
		send_byte(PCT_CHAR, 1'b0);
		send_byte(8'h39, 1'b1);
		// held percent and digit flushed by a percent at message end
		send_byte(PCT_CHAR, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(PCT_CHAR, 1'b1);
	endtask

	task automatic test_random_gaps();
		int sent;
		sent = 0;
		send_gaps = 1'b1;
		stall_gaps = 1'b1;
		while (sent < 150) begin
			send_message(12, sent);
		end
	endtask

	task automatic test_streaming();
		int sent;
		sent = 0;
		send_gaps = 1'b0;
		stall_gaps = 1'b0;
		while (sent < 100) begin
			send_message(16, sent);
		end
	endtask

	task automatic test_backpressure();
		int sent;
		sent = 0;
		send_gaps = 1'b0;
		stall_gaps = 1'b1;
		hold_req = 1'b1;
		while (sent < 50) begin
			send_message(12, sent);
		end
		send_gaps = 1'b1;
		hold_req = 1'b1;
		while (sent < 150) begin
			send_message(12, sent);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_message = 1'b0;
		pend_state = HELD_NONE;
		pend_hex = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_gaps();
		test_streaming();
		test_backpressure();

		@(negedge clk);
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/pctd_pkg.sv
sv/pctd_core.sv
sv/pctd_fifo.sv
sv/permissive_percent_decoder.sv
tb/tb_top.sv
